// File: design/avs_pkg.sv
package avs_pkg;

  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned SpeedW     = 16;
  localparam int unsigned LimitW     = 15;
  localparam int unsigned MissionW   = 4;

  localparam logic [15:0] ReadyDelayReset = 16'd5000;
  localparam logic [15:0] BrakeHoldReset  = 16'd15000;
  localparam logic [14:0] StopLimitReset  = 15'd2560;

  localparam logic [3:0] MissionNone   = 4'd0;
  localparam logic [3:0] MissionManual = 4'd10;

  typedef enum logic [2:0] {
    ST_OFF      = 3'd0,
    ST_READY    = 3'd1,
    ST_DRIVING  = 3'd2,
    ST_BRAKE    = 3'd3,
    ST_FINISHED = 3'd4
  } drive_state_t;

  typedef enum logic [2:0] {
    MODE_UPDATE = 3'd0,
    MODE_SELECT = 3'd1,
    MODE_BRAKE  = 3'd2,
    MODE_FINISH = 3'd3,
    MODE_GO     = 3'd4,
    MODE_RESET  = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    REG_READY_DELAY = 2'd0,
    REG_BRAKE_HOLD  = 2'd1,
    REG_STOP_LIMIT  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]               mode;
    logic [TimeW-1:0]         now_ms;
    logic [MissionW-1:0]      mission_code;
    logic signed [SpeedW-1:0] speed_rear_left;
    logic signed [SpeedW-1:0] speed_rear_right;
    logic signed [SpeedW-1:0] speed_front_left;
    logic signed [SpeedW-1:0] speed_front_right;
  } event_t;

  typedef struct packed {
    logic [15:0] ready_delay_ms;
    logic [15:0] brake_hold_ms;
    logic [14:0] stop_speed_limit;
  } cfg_t;

  typedef struct packed {
    logic                accepted;
    logic [2:0]          drive_state;
    logic [MissionW-1:0] active_mission;
    logic                finish_flag;
    logic                brake_flag;
    logic                go_flag;
    logic                may_drive;
  } result_t;

endpackage

// File: design/avs_in_stage.sv
module avs_in_stage
  import avs_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_stall,
  input  event_t ev_in,
  input  logic   take,
  output logic   s1_valid,
  output event_t ev
);

  logic s1_valid_next;
  logic load;

  assign in_stall = s1_valid && !take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    if (load) begin
      s1_valid_next = 1'b1;
    end else if (take) begin
      s1_valid_next = 1'b0;
    end else begin
      s1_valid_next = s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      ev <= ev_in;
    end
  end

endmodule

// File: design/avs_ctrl.sv
module avs_ctrl
  import avs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  event_t  ev,
  input  cfg_t    cfg,
  output result_t res
);

  drive_state_t        state, state_next;
  logic [MissionW-1:0] mission, mission_next;
  logic                finish_req, finish_req_next;
  logic                brake_req, brake_req_next;
  logic                go_req, go_req_next;
  logic [TimeW-1:0]    ready_stamp, ready_stamp_next;
  logic [TimeW-1:0]    brake_stamp, brake_stamp_next;
  logic                acc;

  logic [TimeW-1:0]         ready_age, brake_age;
  logic                     ready_done, brake_done;
  logic signed [SpeedW-1:0] lim;
  logic                     speeds_low;

  assign ready_age  = ev.now_ms - ready_stamp;
  assign brake_age  = ev.now_ms - brake_stamp;
  assign ready_done = ready_age >= {{(TimeW-16){1'b0}}, cfg.ready_delay_ms};
  assign brake_done = brake_age >= {{(TimeW-16){1'b0}}, cfg.brake_hold_ms};
  assign lim        = $signed({1'b0, cfg.stop_speed_limit});
  assign speeds_low = (ev.speed_rear_left <= lim) && (ev.speed_rear_right <= lim) &&
                      (ev.speed_front_left <= lim) && (ev.speed_front_right <= lim);

  always_comb begin
    state_next       = state;
    mission_next     = mission;
    finish_req_next  = finish_req;
    brake_req_next   = brake_req;
    go_req_next      = go_req;
    ready_stamp_next = ready_stamp;
    brake_stamp_next = brake_stamp;
    acc              = 1'b0;

    unique case (mode_t'(ev.mode))
      MODE_UPDATE: begin
        unique case (state)
          ST_OFF: begin
            if (mission != MissionNone) begin
              state_next       = ST_READY;
              ready_stamp_next = ev.now_ms;
              acc              = 1'b1;
            end
          end
          ST_READY: begin
            priority if (brake_req) begin
              state_next       = ST_BRAKE;
              brake_stamp_next = ev.now_ms;
              acc              = 1'b1;
            end else if (go_req && ready_done) begin
              state_next = ST_DRIVING;
              acc        = 1'b1;
            end else begin
            end
          end
          ST_DRIVING: begin
            priority if (brake_req) begin
              state_next       = ST_BRAKE;
              brake_stamp_next = ev.now_ms;
              acc              = 1'b1;
            end else if (finish_req) begin
              acc = 1'b1;
              if (speeds_low) begin
                state_next = ST_FINISHED;
              end else begin
                state_next       = ST_BRAKE;
                brake_stamp_next = ev.now_ms;
              end
            end else begin
            end
          end
          ST_BRAKE: begin
            if (brake_done) begin
              state_next      = ST_OFF;
              mission_next    = MissionNone;
              finish_req_next = 1'b0;
              brake_req_next  = 1'b0;
              go_req_next     = 1'b0;
              acc             = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      MODE_SELECT: begin
        if (ev.mission_code != MissionNone && ev.mission_code <= MissionManual &&
            mission == MissionNone) begin
          mission_next = ev.mission_code;
          acc          = 1'b1;
        end
      end
      MODE_BRAKE: begin
        if (state == ST_READY || state == ST_DRIVING) begin
          brake_req_next = 1'b1;
          acc            = 1'b1;
        end
      end
      MODE_FINISH: begin
        if (state == ST_DRIVING) begin
          finish_req_next = 1'b1;
          acc             = 1'b1;
        end
      end
      MODE_GO: begin
        if (state == ST_READY) begin
          go_req_next = 1'b1;
          acc         = 1'b1;
        end
      end
      MODE_RESET: begin
        state_next      = ST_OFF;
        mission_next    = MissionNone;
        finish_req_next = 1'b0;
        brake_req_next  = 1'b0;
        go_req_next     = 1'b0;
        acc             = 1'b1;
      end
      default: begin
        // modes six and seven: no effect
      end
    endcase

    res.accepted       = acc;
    res.drive_state    = state_next;
    res.active_mission = mission_next;
    res.finish_flag    = finish_req_next;
    res.brake_flag     = brake_req_next;
    res.go_flag        = go_req_next;
    res.may_drive      = (state_next == ST_DRIVING) || (mission_next == MissionManual);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_OFF;
      mission     <= MissionNone;
      finish_req  <= 1'b0;
      brake_req   <= 1'b0;
      go_req      <= 1'b0;
      ready_stamp <= '0;
      brake_stamp <= '0;
    end else if (fire) begin
      state       <= state_next;
      mission     <= mission_next;
      finish_req  <= finish_req_next;
      brake_req   <= brake_req_next;
      go_req      <= go_req_next;
      ready_stamp <= ready_stamp_next;
      brake_stamp <= brake_stamp_next;
    end
  end

  a_reset_event: assert property (@(posedge clk) disable iff (rst)
    fire && ev.mode == MODE_RESET |=>
      state == ST_OFF && mission == MissionNone && !finish_req && !brake_req && !go_req)
    else $error("reset event left state behind");

  a_finish_from_driving: assert property (@(posedge clk) disable iff (rst)
    fire && state != ST_DRIVING && state != ST_FINISHED |=> state != ST_FINISHED)
    else $error("finished reached from a state other than driving");

  a_requests_hold_state: assert property (@(posedge clk) disable iff (rst)
    fire && ev.mode != MODE_UPDATE && ev.mode != MODE_RESET |=> state == $past(state))
    else $error("request event changed drive state");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(state) && $stable(mission) && $stable(brake_stamp))
    else $error("state moved without an event");

endmodule

// File: design/avs_out_stage.sv
module avs_out_stage
  import avs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res_in,
  output logic    room,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t res
);

  logic out_valid_next;

  assign room = !out_valid || !out_stall;

  always_comb begin
    if (load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_in;
    end
  end

endmodule

// File: design/autonomous_vehicle_supervisor_fsm.sv
// Channel  Direction  Handshake            Payload
// in       request    in_valid / in_stall  mode, now_ms, mission_code, four wheel speeds
// out      result     out_valid / out_stall accepted, drive_state, active_mission, flags
// cfg      write      cfg_we               cfg_index (0..2), cfg_data (16 bit)
//
// One event per cycle sustained while out_stall is low; a request waits in the input register
// until the result register has room, and its result is then loaded there.
// The input register feeds the transition logic, whose answer lands in the result
// register in the same cycle the supervisor state updates.
// rst is synchronous: state off, no mission, requests clear, stamps zero, config
// back to 5000 / 15000 / 2560.
// A stalled result holds; one more request is taken into the input register meanwhile.
module autonomous_vehicle_supervisor_fsm
  import avs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // request channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               mode,
  input  logic [TimeW-1:0]         now_ms,
  input  logic [MissionW-1:0]      mission_code,
  input  logic signed [SpeedW-1:0] speed_rear_left,
  input  logic signed [SpeedW-1:0] speed_rear_right,
  input  logic signed [SpeedW-1:0] speed_front_left,
  input  logic signed [SpeedW-1:0] speed_front_right,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     accepted,
  output logic [2:0]               drive_state,
  output logic [MissionW-1:0]      active_mission,
  output logic                     finish_flag,
  output logic                     brake_flag,
  output logic                     go_flag,
  output logic                     may_drive,
  // configuration writes
  input  logic                     cfg_we,
  input  logic [CfgIdxW-1:0]       cfg_index,
  input  logic [CfgWidth-1:0]      cfg_data
);

  event_t  ev_in, ev;
  cfg_t    cfg;
  result_t res_core, res;
  logic    s1_valid;
  logic    room;
  logic    take;

  assign ev_in.mode              = mode;
  assign ev_in.now_ms            = now_ms;
  assign ev_in.mission_code      = mission_code;
  assign ev_in.speed_rear_left   = speed_rear_left;
  assign ev_in.speed_rear_right  = speed_rear_right;
  assign ev_in.speed_front_left  = speed_front_left;
  assign ev_in.speed_front_right = speed_front_right;

  // the request in the input register is worked whenever the result register has room
  assign take = s1_valid && room;

  // configuration registers; index three is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ready_delay_ms   <= ReadyDelayReset;
      cfg.brake_hold_ms    <= BrakeHoldReset;
      cfg.stop_speed_limit <= StopLimitReset;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_READY_DELAY: cfg.ready_delay_ms   <= cfg_data;
        REG_BRAKE_HOLD:  cfg.brake_hold_ms    <= cfg_data;
        REG_STOP_LIMIT:  cfg.stop_speed_limit <= cfg_data[LimitW-1:0];
        default: begin
        end
      endcase
    end
  end

  avs_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .ev_in    (ev_in),
    .take     (take),
    .s1_valid (s1_valid),
    .ev       (ev)
  );

  avs_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .fire (take),
    .ev   (ev),
    .cfg  (cfg),
    .res  (res_core)
  );

  avs_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .res_in    (res_core),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign accepted       = res.accepted;
  assign drive_state    = res.drive_state;
  assign active_mission = res.active_mission;
  assign finish_flag    = res.finish_flag;
  assign brake_flag     = res.brake_flag;
  assign go_flag        = res.go_flag;
  assign may_drive      = res.may_drive;

endmodule
